### rtl/core/dwrr_pkg.sv
// ----------------------------------------------------------------------------
// dwrr_pkg
// Shared types and constants of the deficit weighted round robin scheduler.
// ----------------------------------------------------------------------------
package dwrr_pkg;

  localparam int unsigned MaxPathsDefault = 8;
  localparam int unsigned SlotW    = 3;
  localparam int unsigned WeightW  = 32;
  localparam int unsigned RttW     = 32;
  localparam int unsigned DeficitW = 34;
  localparam int unsigned MaskW    = 8;

  typedef enum logic {
    ACT_METRICS  = 1'b0,
    ACT_SCHEDULE = 1'b1
  } action_e;

  typedef struct packed {
    logic               action;
    logic [SlotW-1:0]   slot;
    logic [WeightW-1:0] path_weight_in;
    logic [RttW-1:0]    smoothed_rtt_us;
    logic [MaskW-1:0]   active_mask;
    logic [MaskW-1:0]   can_send_mask;
    logic               is_datagram;
    logic               reinject;
    logic [SlotW-1:0]   origin_slot;
    logic               cwnd_gate;
  } req_t;

  typedef struct packed {
    logic [SlotW-1:0] chosen_slot;
    logic             path_found;
    logic             cong_blocked;
  } rsp_t;

  // Controller to datapath commands.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,       // capture request, clear scan state
    CMD_WRITE,      // write metrics
    CMD_CHECK,      // scan one slot: round-done check, member count
    CMD_ROUND,      // resample membership, clear non-members
    CMD_WMIN,       // scan one slot: min weight, member count
    CMD_DIV_START,  // start division for current slot
    CMD_DIV_STEP,   // one quotient bit
    CMD_DIV_DONE,   // add quotient into deficit
    CMD_RTT,        // scan one slot: lowest RTT
    CMD_BEST,       // scan one slot: highest deficit
    CMD_SINGLE,     // resolve single member
    CMD_COMMIT      // decrement winner, form result
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic idx_clr;  // clear slot index
    logic idx_inc;  // advance slot index
  } ctl_t;

  typedef struct packed {
    logic       last_idx;
    logic       div_last;
    logic       round_done;
    logic       dgram;
    logic       metrics;
    logic [1:0] members;  // 0, 1 or 2 (two or more)
  } sts_t;

endpackage

### rtl/core/deficit_wrr_path_scheduler.sv
// ----------------------------------------------------------------------------
// deficit_wrr_path_scheduler
// Multipath packet scheduler: deficit weighted round robin over path slots.
// ----------------------------------------------------------------------------
// One request channel (in_valid_i/in_ready_o/in_data_i) and one result
// channel (out_valid_o/out_ready_i/out_data_o), valid/ready handshakes.
// A metrics request writes one slot's weight and RTT; a schedule request
// returns a chosen slot. Every request gives exactly one result.
// Requests are handled one at a time by a sequencer stepping over slots.
// Request kinds (slots: MaxPaths capped at 8): metrics; lowest-RTT; datagram
// without round start; datagram that starts a round, which runs the
// bit-serial divider once per slot (weight / least member weight, one
// quotient bit a cycle).
// The next request can be taken in the cycle after the result leaves.
// Reset clears all tables, deficits and round membership; no clearing pass.
// A stalled result stays on out_data_o; no request is taken until it leaves.
// ----------------------------------------------------------------------------
module deficit_wrr_path_scheduler #(
  parameter int unsigned MaxPaths = dwrr_pkg::MaxPathsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dwrr_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dwrr_pkg::rsp_t out_data_o
);
  import dwrr_pkg::*;

  ctl_t ctl;
  sts_t sts;

  dwrr_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .ctl_o(ctl)
  );

  dwrr_datapath #(.MaxPaths(MaxPaths)) u_dp (
    .clk_i, .rst_ni, .req_i(in_data_i), .ctl_i(ctl), .sts_o(sts),
    .rsp_o(out_data_o)
  );

endmodule

### rtl/core/dwrr_datapath.sv
// ----------------------------------------------------------------------------
// dwrr_datapath
// Slot tables, slot scan registers and a bit-serial divider.
// ----------------------------------------------------------------------------
module dwrr_datapath #(
  parameter int unsigned MaxPaths = dwrr_pkg::MaxPathsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dwrr_pkg::req_t req_i,
  input  dwrr_pkg::ctl_t ctl_i,
  output dwrr_pkg::sts_t sts_o,
  output dwrr_pkg::rsp_t rsp_o
);
  import dwrr_pkg::*;

  localparam int unsigned NSlot = (MaxPaths < MaskW) ? MaxPaths : MaskW;
  localparam int unsigned IdxW  = (NSlot > 1) ? $clog2(NSlot) : 1;
  localparam logic signed [DeficitW-1:0] DefMin = {1'b1, {(DeficitW-1){1'b0}}};

  logic [WeightW-1:0]        weight_q [NSlot];
  logic [RttW-1:0]           rtt_q    [NSlot];
  logic signed [DeficitW-1:0] def_q   [NSlot];
  logic [NSlot-1:0]          member_q;

  req_t             req_q;
  logic [IdxW-1:0]  idx_q;
  logic             done_q;
  logic [WeightW-1:0] wmin_q;
  logic [1:0]       cnt_q;
  logic [SlotW-1:0] pick_q;
  logic             found_q, any_q;
  logic [RttW-1:0]  brtt_q;
  logic signed [DeficitW-1:0] bdef_q;
  logic [WeightW-1:0] rem_q, quo_q, dvd_q;
  logic [5:0]       dcnt_q;
  rsp_t             rsp_q;

  logic [NSlot-1:0] act, cs;
  logic             mem_i, act_i, cs_i;
  logic [WeightW-1:0] effw;
  logic [WeightW:0]   trial;
  logic [WeightW-1:0] qfix;
  logic [SlotW-1:0]   idx_s;

  always_comb begin
    act   = req_q.active_mask[NSlot-1:0];
    cs    = req_q.can_send_mask[NSlot-1:0];
    mem_i = member_q[idx_q];
    act_i = act[idx_q];
    cs_i  = cs[idx_q];
    effw  = (weight_q[idx_q] == '0) ? WeightW'(1) : weight_q[idx_q];
    trial = {rem_q, dvd_q[WeightW-1]} - {1'b0, wmin_q};
    qfix  = (quo_q == '0) ? WeightW'(1) : quo_q;
    idx_s = SlotW'(idx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSlot; i++) begin
        weight_q[i] <= '0;
        rtt_q[i]    <= '0;
        def_q[i]    <= '0;
      end
      member_q <= '0;
      idx_q    <= '0;
      rsp_q    <= '0;
    end else begin
      if (ctl_i.idx_clr) begin
        idx_q <= '0;
      end else if (ctl_i.idx_inc) begin
        idx_q <= idx_q + IdxW'(1);
      end
      case (ctl_i.cmd)
        CMD_WRITE: begin
          if (32'(req_q.slot) < NSlot) begin
            weight_q[req_q.slot[IdxW-1:0]] <= req_q.path_weight_in;
            rtt_q[req_q.slot[IdxW-1:0]]    <= req_q.smoothed_rtt_us;
          end
          rsp_q <= '0;
        end
        CMD_ROUND: begin
          member_q <= act;
          for (int i = 0; i < NSlot; i++) begin
            if (!act[i]) def_q[i] <= '0;
          end
        end
        CMD_DIV_DONE: begin
          if (mem_i) def_q[idx_q] <= def_q[idx_q] + $signed({2'b00, qfix});
        end
        CMD_COMMIT: begin
          if (found_q && cnt_q == 2'd2 && def_q[pick_q[IdxW-1:0]] != DefMin) begin
            def_q[pick_q[IdxW-1:0]] <= def_q[pick_q[IdxW-1:0]] - DeficitW'(1);
          end
          rsp_q.chosen_slot  <= found_q ? pick_q : '0;
          rsp_q.path_found   <= found_q;
          rsp_q.cong_blocked <= (cnt_q == 2'd0) ? (any_q && !found_q) : !found_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.cmd)
      CMD_LOAD: begin
        req_q   <= req_i;
        done_q  <= 1'b1;
        wmin_q  <= '1;
        cnt_q   <= '0;
        found_q <= 1'b0;
        any_q   <= 1'b0;
        pick_q  <= '0;
      end
      CMD_CHECK: begin
        if (mem_i && def_q[idx_q] > 0) done_q <= 1'b0;
        if (mem_i) begin
          cnt_q  <= (cnt_q == 2'd0) ? 2'd1 : 2'd2;
          pick_q <= idx_s;
        end
      end
      CMD_ROUND: begin
        cnt_q <= '0;
      end
      CMD_WMIN: begin
        if (mem_i) begin
          cnt_q  <= (cnt_q == 2'd0) ? 2'd1 : 2'd2;
          pick_q <= idx_s;
          if (effw < wmin_q) wmin_q <= effw;
        end
      end
      CMD_DIV_START: begin
        dvd_q  <= effw;
        rem_q  <= '0;
        quo_q  <= '0;
        dcnt_q <= '0;
      end
      CMD_DIV_STEP: begin
        dvd_q  <= {dvd_q[WeightW-2:0], 1'b0};
        dcnt_q <= dcnt_q + 6'd1;
        if (!trial[WeightW]) begin
          rem_q <= trial[WeightW-1:0];
          quo_q <= {quo_q[WeightW-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[WeightW-2:0], dvd_q[WeightW-1]};
          quo_q <= {quo_q[WeightW-2:0], 1'b0};
        end
      end
      CMD_RTT: begin
        if (act_i && !(req_q.reinject && req_q.origin_slot == idx_s)) begin
          any_q <= 1'b1;
          if (cs_i && (!found_q || rtt_q[idx_q] < brtt_q)) begin
            brtt_q  <= rtt_q[idx_q];
            pick_q  <= idx_s;
            found_q <= 1'b1;
          end
        end
      end
      CMD_BEST: begin
        if (mem_i && act_i && (!req_q.cwnd_gate || cs_i) &&
            (!found_q || def_q[idx_q] > bdef_q)) begin
          bdef_q  <= def_q[idx_q];
          pick_q  <= idx_s;
          found_q <= 1'b1;
        end
      end
      CMD_SINGLE: begin
        found_q <= act[pick_q[IdxW-1:0]] && cs[pick_q[IdxW-1:0]];
      end
      default: ;
    endcase
  end

  assign sts_o.last_idx   = (32'(idx_q) == NSlot - 1);
  assign sts_o.div_last   = (dcnt_q == 6'(WeightW - 1));
  assign sts_o.round_done = done_q;
  assign sts_o.dgram      = req_q.is_datagram;
  assign sts_o.metrics    = (req_q.action == ACT_METRICS);
  assign sts_o.members    = cnt_q;
  assign rsp_o            = rsp_q;

endmodule

### rtl/core/dwrr_ctrl.sv
// ----------------------------------------------------------------------------
// dwrr_ctrl
// Sequencer: request handshake, scan order, round start and result handoff.
// ----------------------------------------------------------------------------
module dwrr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  dwrr_pkg::sts_t sts_i,
  output dwrr_pkg::ctl_t ctl_o
);
  import dwrr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_CHECK, S_ROUND, S_WMIN, S_DSTART, S_DSTEP,
    S_DDONE, S_PICK, S_RTT, S_BEST, S_SINGLE, S_COMMIT, S_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    ctl_o = '{cmd: CMD_NONE, idx_clr: 1'b0, idx_inc: 1'b0};
    case (state_q)
      S_IDLE:     begin ctl_o.cmd = in_valid_i ? CMD_LOAD : CMD_NONE; ctl_o.idx_clr = 1'b1; end
      S_DISPATCH: begin ctl_o.cmd = sts_i.metrics ? CMD_WRITE : CMD_NONE; end
      S_CHECK:    begin ctl_o.cmd = CMD_CHECK; ctl_o.idx_inc = 1'b1; end
      S_ROUND: begin
        ctl_o.cmd     = sts_i.round_done ? CMD_ROUND : CMD_NONE;
        ctl_o.idx_clr = 1'b1;
      end
      S_WMIN: begin
        ctl_o.cmd     = CMD_WMIN;
        ctl_o.idx_inc = 1'b1;
        ctl_o.idx_clr = sts_i.last_idx;
      end
      S_DSTART:   begin ctl_o.cmd = CMD_DIV_START; end
      S_DSTEP:    begin ctl_o.cmd = CMD_DIV_STEP; end
      S_DDONE:    begin ctl_o.cmd = CMD_DIV_DONE; ctl_o.idx_inc = 1'b1; end
      S_PICK:     begin ctl_o.idx_clr = 1'b1; end
      S_RTT:      begin ctl_o.cmd = CMD_RTT; ctl_o.idx_inc = 1'b1; end
      S_BEST:     begin ctl_o.cmd = CMD_BEST; ctl_o.idx_inc = 1'b1; end
      S_SINGLE:   begin ctl_o.cmd = CMD_SINGLE; end
      S_COMMIT:   begin ctl_o.cmd = CMD_COMMIT; end
      default:    ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_DISPATCH;
        end
        S_DISPATCH: begin
          if (sts_i.metrics) begin
            state_q     <= S_OUT;
            out_valid_q <= 1'b1;
          end else if (sts_i.dgram) begin
            state_q <= S_CHECK;
          end else begin
            state_q <= S_RTT;
          end
        end
        S_CHECK: begin
          if (sts_i.last_idx) state_q <= S_ROUND;
        end
        S_ROUND: begin
          // a new round starts only when the round is done; else go to S_PICK
          state_q <= sts_i.round_done ? S_WMIN : S_PICK;
        end
        S_WMIN: begin
          if (sts_i.last_idx) state_q <= S_DSTART;
        end
        S_DSTART: state_q <= S_DSTEP;
        S_DSTEP: begin
          if (sts_i.div_last) state_q <= S_DDONE;
        end
        S_DDONE: begin
          state_q <= sts_i.last_idx ? S_PICK : S_DSTART;
        end
        S_PICK: begin
          case (sts_i.members)
            2'd0:    state_q <= S_RTT;
            2'd1:    state_q <= S_SINGLE;
            default: state_q <= S_BEST;
          endcase
        end
        S_RTT, S_BEST: begin
          if (sts_i.last_idx) state_q <= S_COMMIT;
        end
        S_SINGLE: state_q <= S_COMMIT;
        S_COMMIT: begin
          state_q     <= S_OUT;
          out_valid_q <= 1'b1;
        end
        S_OUT: begin
          if (out_ready_i) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
